// ===== rtl/rglow_pkg.sv =====
// Package for the radial glow pixel generator.
// Holds sprite geometry, field widths, register indexes and payload structs.
// No dependencies.
package rglow_pkg;

    localparam int SPRITE_SIZE = 256;
    localparam int HALF        = SPRITE_SIZE / 2;
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 8;
    localparam int GAIN_W      = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int RAD_W       = 16;
    localparam int SQ_STAGES   = RAD_W / 2;

    localparam logic [COLOR_W-1:0] COLOR_RST = 8'd255;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED   = 2'd0,
        CFG_GREEN = 2'd1,
        CFG_BLUE  = 2'd2,
        CFG_GAIN  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
    } t_pix_in;

    typedef struct packed {
        logic [COLOR_W-1:0] out_alpha;
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
    } t_pix_out;

endpackage

// ===== rtl/radial_glow_premultiplied_pixel_top.sv =====
// Radial glow pixel generator: one premultiplied BGRA pixel per coordinate.
// Fully pipelined: squares, distance, 8-stage integer square root, alpha, premultiply.
// Depends on rglow_pkg.

// A pixel is taken on every clock where start is high; busy is always low.
// Each result appears on o_pix with o_strobe high for one cycle, in the
// order of the transfers; the pipeline sustains one pixel per clock and
// results cannot be held off. The square root resolves two radius bits per
// stage over eight stages. Color and gain
// registers are sampled late in the pipe; write them only while no pixel is
// in flight.
module radial_glow_premultiplied_pixel_top
    import rglow_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_pix_in               i_pix,
    output logic                  o_strobe,
    output t_pix_out              o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [COLOR_W-1:0] r_red, r_green, r_blue;
    logic [GAIN_W-1:0]  r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= COLOR_RST;
            r_green <= COLOR_RST;
            r_blue  <= COLOR_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RED:   r_red   <= i_cfg_data[COLOR_W-1:0];
                CFG_GREEN: r_green <= i_cfg_data[COLOR_W-1:0];
                CFG_BLUE:  r_blue  <= i_cfg_data[COLOR_W-1:0];
                CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: squared offsets
    logic               r_s1_vld;
    logic [15:0]        r_sqx, r_sqy;
    logic signed [8:0]  dx, dy;
    logic signed [17:0] px, py;

    always_comb begin
        dx = $signed({1'b0, i_pix.pix_x}) - 9'sd128;
        dy = $signed({1'b0, i_pix.pix_y}) - 9'sd128;
        px = dx * dx;
        py = dy * dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else          r_s1_vld <= start;
        r_sqx <= px[15:0];
        r_sqy <= py[15:0];
    end

    // stage 2: distance squared, outside test, square root feed
    logic        r_sq_vld  [0:SQ_STAGES];
    logic        r_sq_out  [0:SQ_STAGES];
    logic [31:0] r_sq_rad  [0:SQ_STAGES];
    logic [17:0] r_sq_rem  [0:SQ_STAGES];
    logic [15:0] r_sq_root [0:SQ_STAGES];
    logic [16:0] d2;

    assign d2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_vld[0] <= 1'b0;
        else          r_sq_vld[0] <= r_s1_vld;
        r_sq_out[0]  <= (d2[16:14] != 3'd0);
        r_sq_rad[0]  <= {d2[13:0], 18'd0};
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    // square root: two result bits per stage
    genvar g;
    generate
        for (g = 0; g < SQ_STAGES; g++) begin : g_sqrt
            logic [17:0] n_rem;
            logic [15:0] n_root;
            logic [31:0] n_rad;

            always_comb begin
                logic [19:0] a;
                logic [17:0] t;
                n_rem  = r_sq_rem[g];
                n_root = r_sq_root[g];
                n_rad  = r_sq_rad[g];
                for (int k = 0; k < 2; k++) begin
                    a = {n_rem, n_rad[31:30]};
                    t = {n_root, 2'b01};
                    if (a >= {2'b00, t}) begin
                        n_rem  = 18'(a - {2'b00, t});
                        n_root = {n_root[14:0], 1'b1};
                    end else begin
                        n_rem  = a[17:0];
                        n_root = {n_root[14:0], 1'b0};
                    end
                    n_rad = {n_rad[29:0], 2'b00};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_sq_vld[g+1] <= 1'b0;
                else          r_sq_vld[g+1] <= r_sq_vld[g];
                r_sq_out[g+1]  <= r_sq_out[g];
                r_sq_rad[g+1]  <= n_rad;
                r_sq_rem[g+1]  <= n_rem;
                r_sq_root[g+1] <= n_root;
            end
        end
    endgenerate

    // alpha: core^2, times gain, times 255 with saturation; zero outside the circle
    logic        r_a1_vld, r_a1_out;
    logic [32:0] r_core2;
    logic [16:0] core;
    logic [33:0] core2;

    assign core  = 17'h10000 - {1'b0, r_sq_root[SQ_STAGES]};
    assign core2 = core * core;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a1_vld <= 1'b0;
        else          r_a1_vld <= r_sq_vld[SQ_STAGES];
        r_a1_out <= r_sq_out[SQ_STAGES];
        r_core2  <= core2[32:0];
    end

    logic        r_a2_vld, r_a2_out;
    logic [41:0] r_pg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a2_vld <= 1'b0;
        else          r_a2_vld <= r_a1_vld;
        r_a2_out <= r_a1_out;
        r_pg     <= r_core2 * r_gain;
    end

    logic               r_a3_vld;
    logic [COLOR_W-1:0] r_alpha;
    logic [49:0]        q;
    logic [COLOR_W-1:0] n_alpha;

    always_comb begin
        q = {r_pg, 8'd0} - {8'd0, r_pg};
        if (r_a2_out)            n_alpha = '0;
        else if (q[49:48] != '0) n_alpha = 8'd255;
        else                     n_alpha = q[47:40];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a3_vld <= 1'b0;
        else          r_a3_vld <= r_a2_vld;
        r_alpha <= n_alpha;
    end

    // premultiply
    logic               r_m_vld;
    logic [COLOR_W-1:0] r_m_alpha;
    logic [15:0]        r_mr, r_mg, r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_vld <= 1'b0;
        else          r_m_vld <= r_a3_vld;
        r_m_alpha <= r_alpha;
        r_mr      <= r_red * r_alpha;
        r_mg      <= r_green * r_alpha;
        r_mb      <= r_blue * r_alpha;
    end

    // floor(x / 255) for 16-bit x below 65280: (x + (x >> 8) + 1) >> 8
    function automatic logic [COLOR_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    logic     r_o_vld;
    t_pix_out r_o_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_m_vld;
        r_o_pix.out_alpha <= r_m_alpha;
        r_o_pix.out_red   <= div255(r_mr);
        r_o_pix.out_green <= div255(r_mg);
        r_o_pix.out_blue  <= div255(r_mb);
    end

    assign o_strobe = r_o_vld;
    assign o_pix    = r_o_pix;

endmodule
